FILE: src/rfae_pkg.sv
// ---------------------------------------------------------------------------
// rfae_pkg: shared types and constants for the ring frame allocator
// Parameter defaults, FSM states, datapath helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package rfae_pkg;
  localparam int unsigned FrameHeaderBytes   = 40;
  localparam int unsigned AlignBytes         = 16;
  localparam int unsigned ControlHeaderBytes = 128;
  localparam int unsigned MaxFrames          = 1024;
  localparam logic [31:0] ArenaReset         = 32'd65536;
  localparam logic [10:0] CntMax             = 11'd2047;

  localparam logic [0:0] RegArena    = 1'b0;
  localparam logic [0:0] RegMetadata = 1'b1;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeProbe = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAILRD,
    ST_PLACE,
    ST_HEADRD,
    ST_CHECK,
    ST_NEXTRD,
    ST_NEXTUP,
    ST_OUT
  } state_t;

  // Round up to a multiple of AlignBytes (a power of two).
  function automatic logic [33:0] round_up(input logic [33:0] x);
    logic [33:0] s;
    s = x + 34'(AlignBytes - 1);
    return (s / 34'(AlignBytes)) * 34'(AlignBytes);
  endfunction
endpackage
`default_nettype wire

FILE: src/rfae_ram.sv
// ---------------------------------------------------------------------------
// rfae_ram: generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module rfae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/ring_frame_allocator_evict_top.sv
// ---------------------------------------------------------------------------
// ring_frame_allocator_evict_top: circular frame allocator, oldest eviction
// Flow: accept, newest read, slot placement, oldest read, oldest load, check,
//   result; on overflow the oldest read goes straight to the result. Each overlap
//   eviction adds a descriptor RAM read, load and compare; ring-full adds a read.
// Throughput: one request at a time; next request taken the cycle after
//   the result beat has been accepted.
// Reset: synchronous; sequence/offset state cleared, registers to defaults.
//   Descriptor RAMs are not cleared; data of unwritten entries is never used.
// ---------------------------------------------------------------------------
`default_nettype none
module ring_frame_allocator_evict_top #(
  parameter int unsigned FRAME_HEADER_BYTES   = rfae_pkg::FrameHeaderBytes,
  parameter int unsigned CONTROL_HEADER_BYTES = rfae_pkg::ControlHeaderBytes
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // config port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // request stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [31:0]  s_axis_tdata,   // [31:0] payload_bytes
  input  wire logic         s_axis_tuser,   // [0] mode
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [175:0]      m_axis_tdata,   // frame_offset[31:0], frame_seq[95:32],
                                            // evicted_count[106:96], oldest_seq[170:107]
  output logic [1:0]        m_axis_tuser    // [0] status, [1] would_evict
);
  localparam int unsigned AW = $clog2(rfae_pkg::MaxFrames);

  // config registers
  logic [31:0] arena_bytes;
  logic [31:0] metadata_bytes;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      arena_bytes    <= rfae_pkg::ArenaReset;
      metadata_bytes <= '0;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[2])
        rfae_pkg::RegArena:    arena_bytes    <= pwdata;
        rfae_pkg::RegMetadata: metadata_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rfae_pkg::RegArena:    prdata = arena_bytes;
      rfae_pkg::RegMetadata: prdata = metadata_bytes;
      default:               prdata = '0;
    endcase
  end

  // allocator state
  rfae_pkg::state_t state, state_next;
  logic [63:0] lowest_seq, highest_seq;
  logic [31:0] head_offset, tail_offset;

  // request latch
  logic        mode;
  logic [31:0] payload;
  logic [33:0] off;       // chosen slot
  logic [33:0] fsize;
  logic [33:0] ws;        // workspace start (registered)
  logic [10:0] cnt;
  logic        ring_full_r;
  logic [31:0] head_len;  // payload length of oldest frame

  // descriptor RAMs (frame start and payload length)
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   start_q, len_q;

  rfae_ram #(.WIDTH(32), .DEPTH(rfae_pkg::MaxFrames)) u_starts (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(off[31:0]),
    .raddr(ram_raddr), .rdata(start_q)
  );
  rfae_ram #(.WIDTH(32), .DEPTH(rfae_pkg::MaxFrames)) u_lengths (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(payload),
    .raddr(ram_raddr), .rdata(len_q)
  );

  wire logic is_empty = (highest_seq == 64'd0) || (lowest_seq > highest_seq);
  wire logic [63:0] live = highest_seq - lowest_seq + 64'd1;
  wire logic full_now = !is_empty && (live >= 64'(rfae_pkg::MaxFrames));

  // overlap of new slot with oldest frame
  wire logic [33:0] head_end = {2'b0, head_offset} + 34'(FRAME_HEADER_BYTES) + {2'b0, head_len};
  wire logic [33:0] new_end  = off + fsize;
  wire logic overlap = !is_empty && (off < head_end) && ({2'b0, head_offset} < new_end);
  // frame does not fit even at the chosen slot
  wire logic ovf = new_end >= {2'b0, arena_bytes};

  // tail-following slot from the newest frame's length
  wire logic [33:0] tail_cand = rfae_pkg::round_up(
      {2'b0, tail_offset} + 34'(FRAME_HEADER_BYTES) + {2'b0, len_q});
  wire logic [33:0] ws_cand = rfae_pkg::round_up(
      rfae_pkg::round_up(34'(CONTROL_HEADER_BYTES)) + {2'b0, metadata_bytes});

  logic        out_status, out_would;
  logic [31:0] out_off;
  logic [63:0] out_seq;
  logic [10:0] out_cnt;

  assign s_axis_tready = (state == rfae_pkg::ST_IDLE) && !m_axis_tvalid;
  assign m_axis_tdata  = {5'b0, lowest_seq, out_cnt, out_seq, out_off};
  assign m_axis_tuser  = {out_would, out_status};

  // RAM addressing
  always_comb begin
    ram_raddr = highest_seq[AW-1:0];
    case (state)
      rfae_pkg::ST_TAILRD: ram_raddr = highest_seq[AW-1:0];
      rfae_pkg::ST_HEADRD: ram_raddr = lowest_seq[AW-1:0];
      rfae_pkg::ST_NEXTRD: ram_raddr = lowest_seq[AW-1:0];
      default:             ram_raddr = highest_seq[AW-1:0];
    endcase
  end
  assign ram_waddr = AW'(highest_seq + 64'd1);
  assign ram_we    = (state == rfae_pkg::ST_CHECK) && !overlap && (mode == rfae_pkg::ModeAlloc);

  always_comb begin
    state_next = state;
    case (state)
      rfae_pkg::ST_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = rfae_pkg::ST_TAILRD;
      rfae_pkg::ST_TAILRD: state_next = rfae_pkg::ST_PLACE;
      rfae_pkg::ST_PLACE:  state_next = rfae_pkg::ST_HEADRD;
      rfae_pkg::ST_HEADRD: begin
        // after a ring-full drop the new oldest has to be read first
        if (ovf) state_next = rfae_pkg::ST_OUT;
        else if (mode == rfae_pkg::ModeAlloc && ring_full_r) state_next = rfae_pkg::ST_NEXTRD;
        else state_next = rfae_pkg::ST_NEXTUP;
      end
      rfae_pkg::ST_CHECK: begin
        if (mode == rfae_pkg::ModeProbe || !overlap) state_next = rfae_pkg::ST_OUT;
        else state_next = rfae_pkg::ST_NEXTRD;
      end
      rfae_pkg::ST_NEXTRD: state_next = rfae_pkg::ST_NEXTUP;
      rfae_pkg::ST_NEXTUP: state_next = rfae_pkg::ST_CHECK;
      rfae_pkg::ST_OUT:    state_next = rfae_pkg::ST_IDLE;
      default:             state_next = rfae_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rfae_pkg::ST_IDLE;
      lowest_seq    <= '0;
      highest_seq   <= '0;
      head_offset   <= '0;
      tail_offset   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        rfae_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mode    <= s_axis_tuser;
            payload <= s_axis_tdata;
            fsize   <= 34'(FRAME_HEADER_BYTES) + {2'b0, s_axis_tdata};
            ws      <= ws_cand;
            cnt     <= '0;
          end
        end
        rfae_pkg::ST_PLACE: begin
          // newest length arrived; choose slot
          if (is_empty || (tail_cand + fsize >= {2'b0, arena_bytes})) off <= ws;
          else off <= tail_cand;
          ring_full_r <= full_now;
        end
        rfae_pkg::ST_HEADRD: begin
          if (ovf) begin
            out_status <= 1'b1;
            out_off    <= '0;
            out_seq    <= '0;
            out_cnt    <= '0;
            out_would  <= 1'b0;
          end else if (mode == rfae_pkg::ModeAlloc && ring_full_r) begin
            // ring full: drop oldest before overlap checks
            cnt <= 11'd1;
            if (lowest_seq == highest_seq) begin
              head_offset <= '0;
              tail_offset <= '0;
            end
            lowest_seq <= lowest_seq + 64'd1;
          end
        end
        rfae_pkg::ST_CHECK: begin
          if (mode == rfae_pkg::ModeProbe) begin
            out_status <= 1'b0;
            out_off    <= off[31:0];
            out_seq    <= highest_seq + 64'd1;
            out_cnt    <= '0;
            out_would  <= ring_full_r || overlap;
          end else if (overlap) begin
            if (cnt != rfae_pkg::CntMax) cnt <= cnt + 11'd1;
            if (lowest_seq == highest_seq) begin
              head_offset <= '0;
              tail_offset <= '0;
            end
            lowest_seq <= lowest_seq + 64'd1;
          end else begin
            highest_seq <= highest_seq + 64'd1;
            if (lowest_seq == 64'd0) lowest_seq <= highest_seq + 64'd1;
            if (is_empty || head_offset == 32'd0) head_offset <= off[31:0];
            tail_offset <= off[31:0];
            out_status  <= 1'b0;
            out_off     <= off[31:0];
            out_seq     <= highest_seq + 64'd1;
            out_cnt     <= cnt;
            out_would   <= cnt != 11'd0;
          end
        end
        rfae_pkg::ST_NEXTUP: begin
          // oldest frame's start and length are in RAM outputs now
          if (!is_empty) head_offset <= start_q;
          head_len <= len_q;
        end
        rfae_pkg::ST_OUT: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
